[sv/lattice_window_vacancy_energy_macros.svh]
// ----------------------------------------------------------------------------
// Lattice window vacancy energy: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LATTICE_WINDOW_VACANCY_ENERGY_MACROS_SVH
`define LATTICE_WINDOW_VACANCY_ENERGY_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LWVE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LWVE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/lwve_pkg.sv]
// ----------------------------------------------------------------------------
// Lattice window vacancy energy: package
// Widths, codes, handshake structs and small helper functions.
// ----------------------------------------------------------------------------
package lwve_pkg;

    // Lattice geometry.
    localparam int MAX_DIM   = 32;
    localparam int COORD_W   = $clog2(MAX_DIM);
    localparam int EXT_W     = COORD_W + 1;
    localparam int ADDR_W    = 3 * COORD_W;
    localparam int SITE_COUNT = MAX_DIM * MAX_DIM * MAX_DIM;
    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(SITE_COUNT - 1);
    localparam logic [EXT_W-1:0]  EXT_MIN   = EXT_W'(4);
    localparam logic [EXT_W-1:0]  EXT_MAX   = EXT_W'(MAX_DIM);

    // Window walk.
    localparam logic [2:0] WIN_LAST  = 3'd6;
    localparam logic [EXT_W-1:0] WIN_HALF = EXT_W'(3);
    localparam int COUNT_W   = 9;
    localparam logic [COUNT_W-1:0] WIN_SITES = 9'd343;

    // Field widths.
    localparam int VALUE_W   = 8;
    localparam int ENERGY_W  = 22;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 6;

    // Energy scaling: floor((2031616*count + 285) / 570) - 8192. Since
    // 2031616 = 3564*570 + 136, the quotient is 3564*count plus
    // floor((136*count + 285) / 570), and the small part stays below 2^16.
    localparam int QUOT_W       = ENERGY_W - 1;
    localparam int PART_W       = 16;
    localparam int RECIP_W      = 17;
    localparam int RECIP_SHIFT  = 26;
    localparam int RECIP_PROD_W = PART_W + RECIP_W;
    localparam logic [QUOT_W-1:0] STEP_QUOT  = 21'd3564;
    localparam logic [PART_W-1:0] STEP_REM   = 16'd136;
    localparam logic [PART_W-1:0] ROUND_BIAS = 16'd285;
    // Rounded-up 2^26 / 570; the quotient is exact for any 16-bit numerator.
    localparam logic [RECIP_W-1:0] RECIP_570 = 17'd117735;
    localparam logic [ENERGY_W-1:0] ENERGY_OFFSET  = 22'd8192;
    localparam logic [ENERGY_W-1:0] ENERGY_AT_ZERO = 22'h3FE000;

    // Input item kinds.
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 2'd2;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REDUCE,
        ST_WALK,
        ST_DRAIN,
        ST_START,
        ST_WAIT
    } ctrl_state_t;

    typedef enum logic [1:0] {
        SC_IDLE,
        SC_SPLIT,
        SC_RECIP,
        SC_DONE
    } scale_state_t;

    // Request from the sequencer to the scaling unit.
    typedef struct packed {
        logic               start;
        logic [COUNT_W-1:0] count;
    } scale_req_t;

    // Finished result from the scaling unit.
    typedef struct packed {
        logic                       done;
        logic [COUNT_W-1:0]         count;
        logic signed [ENERGY_W-1:0] energy;
    } scale_rsp_t;

    // Clamp a size register to the legal extent range.
    function automatic logic [EXT_W-1:0] eff_extent(input logic [CFG_W-1:0] reg_val);
        logic [EXT_W-1:0] s;
        s = reg_val[EXT_W-1:0];
        if (reg_val < CFG_W'(EXT_MIN))
        begin
            s = EXT_MIN;
        end
        else if (reg_val > CFG_W'(EXT_MAX))
        begin
            s = EXT_MAX;
        end
        return s;
    endfunction

    // Step one site forward with wrap at the extent; c is below ext.
    function automatic logic [COORD_W-1:0] wrap_inc(input logic [COORD_W-1:0] c,
                                                    input logic [EXT_W-1:0] ext);
        logic [EXT_W-1:0] t;
        t = {1'b0, c} + EXT_W'(1);
        return (t == ext) ? '0 : t[COORD_W-1:0];
    endfunction

    // First window coordinate, three sites below c with wrap; c is below ext.
    function automatic logic [COORD_W-1:0] wrap_start(input logic [COORD_W-1:0] c,
                                                      input logic [EXT_W-1:0] ext);
        logic [EXT_W-1:0] t;
        t = {1'b0, c} + ext - WIN_HALF;
        if (t >= ext)
        begin
            t = t - ext;
        end
        return t[COORD_W-1:0];
    endfunction

endpackage

[sv/lattice_window_vacancy_energy.sv]
// ----------------------------------------------------------------------------
// Lattice window vacancy energy
// Periodic occupancy lattice with 7x7x7 empty-site count and energy result.
// ----------------------------------------------------------------------------
// After reset the lattice is swept to empty, one site per cycle, and
// s_axis_tready stays low until the sweep ends; configuration beats are taken
// throughout. A write beat (tuser 0) is accepted, its coordinates are brought
// below the extents by repeated subtraction, and the last step of that
// reduction writes the site. A query beat (tuser 1) goes through the same
// coordinate reduction, 343 window reads through the single read port of the
// lattice memory, the drain of the last read, the start of scaling, the split
// and reciprocal scaling steps and the hand-off of the result to the output
// register. The output register lets the next beat be accepted while a result
// waits.
// ----------------------------------------------------------------------------
module lattice_window_vacancy_energy (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // coord_x [4:0], coord_y [9:5], coord_z [14:10], site_value [22:15], zero [23]
    input  logic [23:0] s_axis_tdata,
    // mode [0]
    input  logic [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // empty_count [8:0], energy_q16 [30:9], zero [31]
    output logic [31:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [lwve_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lwve_pkg::CFG_W-1:0]     cfg_data
);

    logic [lwve_pkg::CFG_W-1:0] size_x_reg, size_y_reg, size_z_reg;
    logic                       out_valid_reg, out_valid_next;
    logic [lwve_pkg::COUNT_W-1:0]        out_count_reg;
    logic signed [lwve_pkg::ENERGY_W-1:0] out_energy_reg;

    logic                        ram_we;
    logic [lwve_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
    logic                        ram_wdata, ram_rdata;
    lwve_pkg::scale_req_t        scale_req;
    lwve_pkg::scale_rsp_t        scale_rsp;
    logic                        handoff;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= lwve_pkg::CFG_W'(lwve_pkg::MAX_DIM);
            size_y_reg <= lwve_pkg::CFG_W'(lwve_pkg::MAX_DIM);
            size_z_reg <= lwve_pkg::CFG_W'(lwve_pkg::MAX_DIM);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                lwve_pkg::CFG_SIZE_X: size_x_reg <= cfg_data;
                lwve_pkg::CFG_SIZE_Y: size_y_reg <= cfg_data;
                lwve_pkg::CFG_SIZE_Z: size_z_reg <= cfg_data;
                default:              ;
            endcase
        end
    end

    // The finished result moves to the output register once it is free.
    assign handoff = scale_rsp.done && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (handoff)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (handoff)
        begin
            out_count_reg  <= scale_rsp.count;
            out_energy_reg <= scale_rsp.energy;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_energy_reg, out_count_reg};

    // Sequencer: clearing sweep, coordinate reduction, site write, window walk.
    lwve_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .size_x    (size_x_reg),
        .size_y    (size_y_reg),
        .size_z    (size_z_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_mode   (s_axis_tuser[0]),
        .in_x      (s_axis_tdata[4:0]),
        .in_y      (s_axis_tdata[9:5]),
        .in_z      (s_axis_tdata[14:10]),
        .in_value  (s_axis_tdata[22:15]),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .scale_req (scale_req),
        .handoff   (handoff)
    );

    // Occupancy lattice, one bit per site.
    lwve_ram #(
        .WIDTH (1),
        .DEPTH (lwve_pkg::SITE_COUNT)
    ) u_lattice (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Count to energy conversion.
    lwve_scale u_scale (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (scale_req),
        .handoff (handoff),
        .rsp     (scale_rsp)
    );

endmodule

[sv/lwve_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lwve_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

[sv/lwve_ctrl.sv]
// ----------------------------------------------------------------------------
// Lattice window sequencer
// Clears the lattice, reduces coordinates, writes sites and walks the window.
// ----------------------------------------------------------------------------
module lwve_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [lwve_pkg::CFG_W-1:0]    size_x,
    input  logic [lwve_pkg::CFG_W-1:0]    size_y,
    input  logic [lwve_pkg::CFG_W-1:0]    size_z,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          in_mode,
    input  logic [lwve_pkg::COORD_W-1:0]  in_x,
    input  logic [lwve_pkg::COORD_W-1:0]  in_y,
    input  logic [lwve_pkg::COORD_W-1:0]  in_z,
    input  logic [lwve_pkg::VALUE_W-1:0]  in_value,
    output logic                          ram_we,
    output logic [lwve_pkg::ADDR_W-1:0]   ram_waddr,
    output logic                          ram_wdata,
    output logic [lwve_pkg::ADDR_W-1:0]   ram_raddr,
    input  logic                          ram_rdata,
    output lwve_pkg::scale_req_t          scale_req,
    input  logic                          handoff
);

    lwve_pkg::ctrl_state_t state_reg, state_next;
    logic [lwve_pkg::ADDR_W-1:0]  clr_reg, clr_next;
    logic                         rd_pend_reg, rd_pend_next;
    logic                         mode_reg, mode_next;
    logic                         occ_reg, occ_next;
    logic [lwve_pkg::COORD_W-1:0] cx_reg, cx_next, cy_reg, cy_next, cz_reg, cz_next;
    logic [lwve_pkg::COORD_W-1:0] ex_reg, ex_next, ey_reg, ey_next, ez_reg, ez_next;
    logic [lwve_pkg::COORD_W-1:0] sty_reg, sty_next, stz_reg, stz_next;
    logic [2:0]                   dx_reg, dx_next, dy_reg, dy_next, dz_reg, dz_next;
    logic [lwve_pkg::COUNT_W-1:0] count_reg, count_next;

    logic [lwve_pkg::EXT_W-1:0] sx, sy, sz;
    logic over_x, over_y, over_z;

    // Effective extents and the per-axis reduction compares.
    assign sx = lwve_pkg::eff_extent(size_x);
    assign sy = lwve_pkg::eff_extent(size_y);
    assign sz = lwve_pkg::eff_extent(size_z);
    assign over_x = ({1'b0, cx_reg} >= sx);
    assign over_y = ({1'b0, cy_reg} >= sy);
    assign over_z = ({1'b0, cz_reg} >= sz);

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= lwve_pkg::ST_CLEAR;
            clr_reg     <= '0;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            rd_pend_reg <= rd_pend_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        occ_reg   <= occ_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        cz_reg    <= cz_next;
        ex_reg    <= ex_next;
        ey_reg    <= ey_next;
        ez_reg    <= ez_next;
        sty_reg   <= sty_next;
        stz_reg   <= stz_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        dz_reg    <= dz_next;
        count_reg <= count_next;
    end

    // Next state and outputs.
    always_comb
    begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        rd_pend_next = 1'b0;
        mode_next    = mode_reg;
        occ_next     = occ_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        cz_next      = cz_reg;
        ex_next      = ex_reg;
        ey_next      = ey_reg;
        ez_next      = ez_reg;
        sty_next     = sty_reg;
        stz_next     = stz_reg;
        dx_next      = dx_reg;
        dy_next      = dy_reg;
        dz_next      = dz_reg;
        count_next   = count_reg;
        in_ready     = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = {cx_reg, cy_reg, cz_reg};
        ram_wdata    = occ_reg;
        ram_raddr    = {ex_reg, ey_reg, ez_reg};
        scale_req.start = 1'b0;
        scale_req.count = count_reg;

        // A window read issued last cycle returns its bit now.
        if (rd_pend_reg && !ram_rdata)
        begin
            count_next = count_reg + lwve_pkg::COUNT_W'(1);
        end

        case (state_reg)
            lwve_pkg::ST_CLEAR:
            begin
                // Sweep every site to empty, one per cycle.
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = 1'b0;
                if (clr_reg == lwve_pkg::ADDR_LAST)
                begin
                    state_next = lwve_pkg::ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + lwve_pkg::ADDR_W'(1);
                end
            end
            lwve_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    mode_next  = in_mode;
                    occ_next   = |in_value;
                    cx_next    = in_x;
                    cy_next    = in_y;
                    cz_next    = in_z;
                    state_next = lwve_pkg::ST_REDUCE;
                end
            end
            lwve_pkg::ST_REDUCE:
            begin
                // Subtract the extent until every coordinate is in range.
                if (over_x || over_y || over_z)
                begin
                    if (over_x)
                    begin
                        cx_next = lwve_pkg::COORD_W'({1'b0, cx_reg} - sx);
                    end
                    if (over_y)
                    begin
                        cy_next = lwve_pkg::COORD_W'({1'b0, cy_reg} - sy);
                    end
                    if (over_z)
                    begin
                        cz_next = lwve_pkg::COORD_W'({1'b0, cz_reg} - sz);
                    end
                end
                else if (mode_reg == lwve_pkg::MODE_WRITE)
                begin
                    ram_we     = 1'b1;
                    state_next = lwve_pkg::ST_IDLE;
                end
                else
                begin
                    ex_next    = lwve_pkg::wrap_start(cx_reg, sx);
                    ey_next    = lwve_pkg::wrap_start(cy_reg, sy);
                    ez_next    = lwve_pkg::wrap_start(cz_reg, sz);
                    sty_next   = lwve_pkg::wrap_start(cy_reg, sy);
                    stz_next   = lwve_pkg::wrap_start(cz_reg, sz);
                    dx_next    = '0;
                    dy_next    = '0;
                    dz_next    = '0;
                    count_next = '0;
                    state_next = lwve_pkg::ST_WALK;
                end
            end
            lwve_pkg::ST_WALK:
            begin
                // One window site read per cycle, z fastest.
                rd_pend_next = 1'b1;
                if (dz_reg == lwve_pkg::WIN_LAST)
                begin
                    dz_next = '0;
                    ez_next = stz_reg;
                    if (dy_reg == lwve_pkg::WIN_LAST)
                    begin
                        dy_next = '0;
                        ey_next = sty_reg;
                        dx_next = dx_reg + 3'd1;
                        ex_next = lwve_pkg::wrap_inc(ex_reg, sx);
                        if (dx_reg == lwve_pkg::WIN_LAST)
                        begin
                            state_next = lwve_pkg::ST_DRAIN;
                        end
                    end
                    else
                    begin
                        dy_next = dy_reg + 3'd1;
                        ey_next = lwve_pkg::wrap_inc(ey_reg, sy);
                    end
                end
                else
                begin
                    dz_next = dz_reg + 3'd1;
                    ez_next = lwve_pkg::wrap_inc(ez_reg, sz);
                end
            end
            lwve_pkg::ST_DRAIN:
            begin
                // The last read is counted in this cycle.
                state_next = lwve_pkg::ST_START;
            end
            lwve_pkg::ST_START:
            begin
                scale_req.start = 1'b1;
                state_next      = lwve_pkg::ST_WAIT;
            end
            lwve_pkg::ST_WAIT:
            begin
                if (handoff)
                begin
                    state_next = lwve_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lwve_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[sv/lwve_scale.sv]
// ----------------------------------------------------------------------------
// Energy scaling unit
// Constant division of the scaled count by a split and a reciprocal multiply.
// ----------------------------------------------------------------------------
module lwve_scale (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lwve_pkg::scale_req_t req,
    input  logic                 handoff,
    output lwve_pkg::scale_rsp_t rsp
);

    lwve_pkg::scale_state_t state_reg, state_next;
    logic [lwve_pkg::PART_W-1:0]     part_reg, part_next;
    logic [lwve_pkg::QUOT_W-1:0]     quot_reg, quot_next;
    logic [lwve_pkg::COUNT_W-1:0]    count_reg, count_next;

    logic [lwve_pkg::RECIP_PROD_W-1:0] recip_prod;

    // Small remainder part divided by 570 through the reciprocal.
    assign recip_prod = lwve_pkg::RECIP_PROD_W'(part_reg)
                        * lwve_pkg::RECIP_PROD_W'(lwve_pkg::RECIP_570);

    assign rsp.done   = (state_reg == lwve_pkg::SC_DONE);
    assign rsp.count  = count_reg;
    assign rsp.energy = {1'b0, quot_reg} - lwve_pkg::ENERGY_OFFSET;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lwve_pkg::SC_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        part_reg  <= part_next;
        quot_reg  <= quot_next;
        count_reg <= count_next;
    end

    // Sequencer for the two scaling steps.
    always_comb
    begin
        state_next = state_reg;
        part_next  = part_reg;
        quot_next  = quot_reg;
        count_next = count_reg;

        case (state_reg)
            lwve_pkg::SC_IDLE:
            begin
                if (req.start)
                begin
                    count_next = req.count;
                    state_next = lwve_pkg::SC_SPLIT;
                end
            end
            lwve_pkg::SC_SPLIT:
            begin
                // Whole steps of 3564 and the leftover 136*count plus the bias.
                quot_next  = lwve_pkg::QUOT_W'(count_reg) * lwve_pkg::STEP_QUOT;
                part_next  = lwve_pkg::PART_W'(count_reg) * lwve_pkg::STEP_REM
                             + lwve_pkg::ROUND_BIAS;
                state_next = lwve_pkg::SC_RECIP;
            end
            lwve_pkg::SC_RECIP:
            begin
                quot_next  = quot_reg + lwve_pkg::QUOT_W'(
                                 recip_prod[lwve_pkg::RECIP_PROD_W-1:lwve_pkg::RECIP_SHIFT]);
                state_next = lwve_pkg::SC_DONE;
            end
            lwve_pkg::SC_DONE:
            begin
                if (handoff)
                begin
                    state_next = lwve_pkg::SC_IDLE;
                end
            end
            default:
            begin
                state_next = lwve_pkg::SC_IDLE;
            end
        endcase
    end

endmodule

[sv/lwve_check.sv]
// ----------------------------------------------------------------------------
// Lattice window vacancy energy: port checker
// Concurrent assertions on the top-level ports, attached by bind.
// ----------------------------------------------------------------------------
`include "lattice_window_vacancy_energy_macros.svh"

module lwve_check (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    // A result beat that is held back keeps its value.
    `LWVE_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result beat changed")

    // The block works on one item at a time.
    `LWVE_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input accepted while an item is in work")

    // The count never exceeds the window size.
    `LWVE_ASSERT_NOW(a_count_range, m_axis_tvalid, m_axis_tdata[8:0] <= lwve_pkg::WIN_SITES, "empty count beyond window size")

    // An all-occupied window gives the bare offset energy.
    `LWVE_ASSERT_NOW(a_energy_zero, m_axis_tvalid && (m_axis_tdata[8:0] == 9'd0), m_axis_tdata[30:9] == lwve_pkg::ENERGY_AT_ZERO, "energy wrong for empty count of zero")

endmodule

bind lattice_window_vacancy_energy lwve_check u_check (.*);

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// Lattice window vacancy energy: testbench
// Drives site writes and window queries into the block. A model of the lattice
// inside the bench predicts each empty-site count and its energy, and every
// result beat is checked against those predictions in order. The run covers
// several extent settings, a fully occupied lattice, long output back-pressure
// and random traffic under several idling patterns.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 100000;
    localparam int DRAIN_CYCLES   = 400;
    localparam int WRITE_SETTLE   = 16;
    localparam int HOLD_CYCLES    = 3000;
    localparam logic [lwve_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

    typedef struct packed {
        logic [lwve_pkg::COUNT_W-1:0]         empty_count;
        logic signed [lwve_pkg::ENERGY_W-1:0] energy_q16;
    } vacancy_result_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [23:0]                    s_axis_tdata = '0;
    logic [0:0]                     s_axis_tuser = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [31:0]                    m_axis_tdata;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [lwve_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [lwve_pkg::CFG_W-1:0]     cfg_data = '0;

    // Bench copy of the lattice and of the extent registers.
    bit                         site_occupied [lwve_pkg::SITE_COUNT];
    logic [lwve_pkg::CFG_W-1:0] extent_reg [3];
    vacancy_result_t            pending_vacancy_results [$];

    int fail_count     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_request   = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;

    lattice_window_vacancy_energy dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Size registers below four act as four, above the lattice as the lattice.
    function automatic int lattice_extent(input logic [lwve_pkg::CFG_W-1:0] size_val);
        if (size_val < 4)
        begin
            return 4;
        end
        if (size_val > lwve_pkg::MAX_DIM)
        begin
            return lwve_pkg::MAX_DIM;
        end
        return int'(size_val);
    endfunction

    function automatic int site_slot(input int x, input int y, input int z);
        return (x * lwve_pkg::MAX_DIM + y) * lwve_pkg::MAX_DIM + z;
    endfunction

    // Count the empty sites of the 7x7x7 window and scale the count to energy.
    function automatic vacancy_result_t predict_vacancy(input int cx, input int cy,
                                                        input int cz);
        vacancy_result_t res;
        int     sx;
        int     sy;
        int     sz;
        int     empties;
        longint energy;
        sx = lattice_extent(extent_reg[lwve_pkg::CFG_SIZE_X]);
        sy = lattice_extent(extent_reg[lwve_pkg::CFG_SIZE_Y]);
        sz = lattice_extent(extent_reg[lwve_pkg::CFG_SIZE_Z]);
        empties = 0;
        for (int dx = 0; dx < 7; dx++)
        begin
            for (int dy = 0; dy < 7; dy++)
            begin
                for (int dz = 0; dz < 7; dz++)
                begin
                    if (!site_occupied[site_slot((cx + dx + sx - 3) % sx,
                                                 (cy + dy + sy - 3) % sy,
                                                 (cz + dz + sz - 3) % sz)])
                    begin
                        empties++;
                    end
                end
            end
        end
        energy = (longint'(2031616) * empties + 285) / 570 - 8192;
        res.empty_count = lwve_pkg::COUNT_W'(empties);
        res.energy_q16  = lwve_pkg::ENERGY_W'(energy);
        return res;
    endfunction

    // Track one accepted input beat: a write updates the lattice, a query
    // queues its expected result.
    task automatic track_site_beat(input logic mode,
                                   input logic [lwve_pkg::COORD_W-1:0] x,
                                   input logic [lwve_pkg::COORD_W-1:0] y,
                                   input logic [lwve_pkg::COORD_W-1:0] z,
                                   input logic [lwve_pkg::VALUE_W-1:0] value);
        int cx;
        int cy;
        int cz;
        cx = int'(x) % lattice_extent(extent_reg[lwve_pkg::CFG_SIZE_X]);
        cy = int'(y) % lattice_extent(extent_reg[lwve_pkg::CFG_SIZE_Y]);
        cz = int'(z) % lattice_extent(extent_reg[lwve_pkg::CFG_SIZE_Z]);
        if (mode == lwve_pkg::MODE_WRITE)
        begin
            site_occupied[site_slot(cx, cy, cz)] = (value != 0);
        end
        else
        begin
            pending_vacancy_results.push_back(predict_vacancy(cx, cy, cz));
        end
    endtask

    // Offer one beat from a falling edge and return at the falling edge after
    // it is taken; tvalid stays high for a following beat.
    task automatic send_site_beat(input logic mode,
                                  input logic [lwve_pkg::COORD_W-1:0] x,
                                  input logic [lwve_pkg::COORD_W-1:0] y,
                                  input logic [lwve_pkg::COORD_W-1:0] z,
                                  input logic [lwve_pkg::VALUE_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {1'b0, value, z, y, x};
        s_axis_tuser  = mode;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        track_site_beat(mode, x, y, z, value);
        @(negedge clk);
    endtask

    task automatic write_site(input int x, input int y, input int z, input int value);
        send_site_beat(lwve_pkg::MODE_WRITE, lwve_pkg::COORD_W'(x), lwve_pkg::COORD_W'(y),
                       lwve_pkg::COORD_W'(z), lwve_pkg::VALUE_W'(value));
    endtask

    task automatic query_site(input int x, input int y, input int z);
        send_site_beat(lwve_pkg::MODE_QUERY, lwve_pkg::COORD_W'(x), lwve_pkg::COORD_W'(y),
                       lwve_pkg::COORD_W'(z), '0);
    endtask

    // Wait until every query has answered and a pending write has landed.
    task automatic wait_until_idle();
        s_axis_tvalid = 1'b0;
        while (pending_vacancy_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (WRITE_SETTLE) @(negedge clk);
    endtask

    task automatic write_register(input logic [lwve_pkg::CFG_IDX_W-1:0] index,
                                  input logic [lwve_pkg::CFG_W-1:0] value);
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data  = value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        if (index != CFG_UNMAPPED)
        begin
            extent_reg[index] = value;
        end
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Mostly small extents so that writes crowd the windows; now and then the
    // full lattice or a value outside the legal range.
    task automatic configure_random_sizes();
        logic [lwve_pkg::CFG_W-1:0] size_val;
        for (int r = 0; r < 3; r++)
        begin
            case ($urandom_range(9))
                0:       size_val = lwve_pkg::CFG_W'(lwve_pkg::MAX_DIM);
                1, 2:    size_val = lwve_pkg::CFG_W'($urandom_range(63));
                default: size_val = lwve_pkg::CFG_W'($urandom_range(4, 8));
            endcase
            write_register(lwve_pkg::CFG_IDX_W'(r), size_val);
        end
    endtask

    // Fixed sites at the window edges and at the lattice corners, full sizes.
    task automatic test_directed_sites();
        query_site(0, 0, 0);
        write_site(31, 31, 31, 255);
        write_site(0, 0, 0, 1);
        write_site(3, 3, 3, 128);
        write_site(4, 0, 0, 1);
        query_site(0, 0, 0);
        query_site(31, 31, 31);
        query_site(28, 28, 28);
        write_site(0, 0, 0, 0);
        query_site(0, 0, 0);
        write_site(17, 10, 5, 8'h55);
        write_site(10, 21, 26, 8'hAA);
        query_site(14, 13, 8);
        wait_until_idle();
    endtask

    // Extents below four, above the lattice, an unmapped index, coordinates
    // beyond the extent and size changes over sites already written.
    task automatic test_size_extremes();
        write_register(lwve_pkg::CFG_SIZE_X, 6'd0);
        write_register(lwve_pkg::CFG_SIZE_Y, 6'd3);
        write_register(lwve_pkg::CFG_SIZE_Z, 6'd63);
        write_register(CFG_UNMAPPED, 6'd5);
        write_site(31, 31, 31, 200);
        query_site(31, 31, 31);
        query_site(0, 0, 0);
        query_site(7, 12, 30);
        wait_until_idle();
        write_register(lwve_pkg::CFG_SIZE_X, 6'd33);
        write_register(lwve_pkg::CFG_SIZE_Y, 6'd4);
        write_register(CFG_UNMAPPED, 6'd63);
        query_site(31, 31, 31);
        query_site(3, 3, 31);
        write_site(2, 5, 9, 0);
        query_site(2, 5, 9);
        wait_until_idle();
        write_register(lwve_pkg::CFG_SIZE_X, 6'd32);
        write_register(lwve_pkg::CFG_SIZE_Y, 6'd32);
        write_register(lwve_pkg::CFG_SIZE_Z, 6'd32);
        query_site(30, 1, 16);
        wait_until_idle();
    endtask

    // Occupy every site of a 4x4x4 lattice, so a window sees no vacancy, then
    // empty one site again.
    task automatic test_full_lattice();
        write_register(lwve_pkg::CFG_SIZE_X, 6'd4);
        write_register(lwve_pkg::CFG_SIZE_Y, 6'd4);
        write_register(lwve_pkg::CFG_SIZE_Z, 6'd4);
        for (int x = 0; x < 4; x++)
        begin
            for (int y = 0; y < 4; y++)
            begin
                for (int z = 0; z < 4; z++)
                begin
                    write_site(x + 4 * $urandom_range(7), y + 4 * $urandom_range(7),
                               z + 4 * $urandom_range(7), $urandom_range(1, 255));
                end
            end
        end
        query_site($urandom_range(31), $urandom_range(31), $urandom_range(31));
        write_site($urandom_range(31), $urandom_range(31), $urandom_range(31), 0);
        query_site($urandom_range(31), $urandom_range(31), $urandom_range(31));
        query_site(0, 0, 0);
        wait_until_idle();
    endtask

    // The receiver holds off for a long stretch while queries keep coming, so
    // the output register fills and the input stalls.
    task automatic test_output_backpressure();
        configure_random_sizes();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = HOLD_CYCLES;
        for (int n = 0; n < 8; n++)
        begin
            write_site($urandom_range(31), $urandom_range(31), $urandom_range(31),
                       $urandom_range(255));
            query_site($urandom_range(31), $urandom_range(31), $urandom_range(31));
        end
        wait_until_idle();
    endtask

    // Random writes and queries; queries often land on the last written site.
    task automatic test_random_traffic(input int beats, input int idle_pct,
                                       input int stall_pct);
        int lx;
        int ly;
        int lz;
        lx = 0;
        ly = 0;
        lz = 0;
        configure_random_sizes();
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < beats; n++)
        begin
            if ($urandom_range(99) < 55)
            begin
                lx = $urandom_range(31);
                ly = $urandom_range(31);
                lz = $urandom_range(31);
                write_site(lx, ly, lz,
                           ($urandom_range(99) < 30) ? 0 : $urandom_range(1, 255));
            end
            else if ($urandom_range(1) == 0)
            begin
                query_site(lx, ly, lz);
            end
            else
            begin
                query_site($urandom_range(31), $urandom_range(31), $urandom_range(31));
            end
        end
        wait_until_idle();
    endtask

    // Receiver: random stalls, or a counted hold-off when one is requested.
    always @(negedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            m_axis_tready = 1'b0;
            hold_left--;
        end
        else
        begin
            m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare each result beat with the oldest prediction.
    always @(posedge clk)
    begin : check_results
        vacancy_result_t seen;
        vacancy_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen.empty_count = m_axis_tdata[8:0];
            seen.energy_q16  = m_axis_tdata[30:9];
            if (pending_vacancy_results.size() == 0)
            begin
                $display("%0t: result beat with none expected, actual count %0d energy %0d",
                         $time, seen.empty_count, seen.energy_q16);
                fail_count++;
            end
            else
            begin
                want = pending_vacancy_results.pop_front();
                if (seen.empty_count != want.empty_count)
                begin
                    $display("%0t: empty_count mismatch, expected %0d, actual %0d",
                             $time, want.empty_count, seen.empty_count);
                    fail_count++;
                end
                if (seen.energy_q16 != want.energy_q16)
                begin
                    $display("%0t: energy_q16 mismatch, expected %0d, actual %0d",
                             $time, want.energy_q16, seen.energy_q16);
                    fail_count++;
                end
            end
        end
    end

    // Count cycles in which no channel moves a beat.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
    end

    initial
    begin : watchdog
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        for (int r = 0; r < 3; r++)
        begin
            extent_reg[r] = lwve_pkg::CFG_W'(lwve_pkg::MAX_DIM);
        end
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_sites();
        test_size_extremes();
        test_full_lattice();
        test_output_backpressure();
        test_random_traffic(150, 0, 0);
        test_random_traffic(150, 49, 0);
        test_random_traffic(150, 0, 49);
        test_random_traffic(150, 9, 9);

        // Let any stray result show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+sv
sv/lwve_pkg.sv
sv/lwve_ram.sv
sv/lwve_ctrl.sv
sv/lwve_scale.sv
sv/lattice_window_vacancy_energy.sv
sv/lwve_check.sv
tb/testbench.sv
